FILE: sv/apaf_pkg.sv
// ----------------------------------------------------------------------------
// apaf_pkg
// Shared types, constants and the six-bit armoring function for the
// payload armor fragmenter.
// ----------------------------------------------------------------------------
package apaf_pkg;

  localparam int GROUP_W       = 6;
  localparam int FRAG_LEN_W    = 7;
  localparam int MAX_GROUPS    = 3;
  localparam int JOB_DEPTH_DEF = 4;
  localparam int OUT_DEPTH_DEF = 2;

  localparam logic [FRAG_LEN_W-1:0] FRAG_LEN_RESET = 7'd56;

  // Input beat
  typedef struct packed {
    logic [7:0] data_bits;
    logic [3:0] bit_count;
    logic       message_last;
  } in_item_t;

  // Result beat
  typedef struct packed {
    logic [6:0] armored_char;
    logic       fragment_end;
    logic [2:0] fill_bits;
    logic       run_last;
  } out_item_t;

  // Classified work for the back end: up to three groups of one input
  typedef struct packed {
    logic [MAX_GROUPS-1:0][GROUP_W-1:0] grp;
    logic [1:0]                         num;
    logic [2:0]                         fill;
    logic                               last;
  } job_t;

  // Map a six-bit group to its armored ASCII character
  function automatic logic [6:0] armor_char(input logic [GROUP_W-1:0] v);
    logic [6:0] w;
    w = 7'(v);
    if (w > 7'd39) begin
      w = w + 7'd8;
    end
    return w + 7'd48;
  endfunction

endpackage

FILE: sv/ais_payload_armor_fragmenter.sv
// ----------------------------------------------------------------------------
// ais_payload_armor_fragmenter
// Six-bit payload armoring with fragment boundaries and fill-bit report.
// ----------------------------------------------------------------------------
// Input queue: drive in_data and raise in_push; a beat is taken on an edge
//   with in_push high and in_full low. Each beat carries 1 to 8 message bits,
//   MSB first, and message_last on the closing chunk.
// Result queue: while out_empty is low, out_data holds the oldest character;
//   raise out_pop to take it.
// Config: cfg_data is written on an edge with cfg_valid high (cfg_ready is
//   always high); write only while the block is idle.
// Flow: with empty queues the first character of a beat passes the job queue
//   and the result queue before it shows on out_data. The back end emits one
//   character per cycle while a job waits and the result queue has room; a
//   beat yields 0 to 3 characters (about 1.33 on average for byte chunks); the
//   front takes a beat every cycle while the job queue has room.
// Reset clears both queues, waiting bits and fragment count; fragment length
//   returns to 56.
// Stall: with out_pop held low the result queue fills, then the job queue,
//   then in_full rises; nothing is dropped.
// ----------------------------------------------------------------------------
module ais_payload_armor_fragmenter #(
  parameter int JOB_DEPTH = apaf_pkg::JOB_DEPTH_DEF,
  parameter int OUT_DEPTH = apaf_pkg::OUT_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  apaf_pkg::in_item_t  in_data,
  output logic                in_full,
  output logic                out_empty,
  input  logic                out_pop,
  output apaf_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [6:0]          cfg_data
);
  import apaf_pkg::*;

  logic      job_push, job_full, job_pop, job_empty;
  job_t      job_wdata, job_rdata;
  logic      res_push, res_full;
  out_item_t res_wdata;

  assign cfg_ready = 1'b1;

  // Front: merge and classify
  apaf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .job_push  (job_push),
    .job_wdata (job_wdata),
    .job_full  (job_full)
  );

  // Job queue between front and back
  apaf_fifo #(
    .WIDTH ($bits(job_t)),
    .DEPTH (JOB_DEPTH)
  ) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .wdata (job_wdata),
    .full  (job_full),
    .pop   (job_pop),
    .rdata (job_rdata),
    .empty (job_empty)
  );

  // Back: character sequencer
  apaf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .job_empty (job_empty),
    .job_rdata (job_rdata),
    .job_pop   (job_pop),
    .out_full  (res_full),
    .out_push  (res_push),
    .out_wdata (res_wdata)
  );

  // Result queue
  apaf_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_wdata),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_data),
    .empty (out_empty)
  );

endmodule

FILE: sv/apaf_fifo.sv
// ----------------------------------------------------------------------------
// apaf_fifo
// Small register-based first-in first-out queue with a full/empty handshake.
// ----------------------------------------------------------------------------
module apaf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("fifo occupancy above depth");
`endif

endmodule

FILE: sv/apaf_front.sv
// ----------------------------------------------------------------------------
// apaf_front
// Accept input beats, merge them with the waiting bits and split the result
// into whole six-bit groups plus the padded tail at message end.
// ----------------------------------------------------------------------------
module apaf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  apaf_pkg::in_item_t in_data,
  output logic              in_full,
  output logic              job_push,
  output apaf_pkg::job_t    job_wdata,
  input  logic              job_full
);
  import apaf_pkg::*;

  logic [4:0]  leftover_bits_r, leftover_bits_nxt;
  logic [2:0]  leftover_count_r, leftover_count_nxt;
  logic        accept;
  logic [3:0]  n_sat;
  logic [7:0]  data_mask;
  logic [12:0] acc;
  logic [3:0]  cnt;
  logic [1:0]  full_groups;
  logic [2:0]  rem;
  logic [4:0]  rem_bits;
  logic [5:0]  g_first, g_second, part;
  logic        has_part;
  job_t        job;

  assign in_full = job_full;
  assign accept  = in_push && !job_full;

  // Merge and classify
  always_comb begin
    n_sat     = (in_data.bit_count > 4'd8) ? 4'd8 : in_data.bit_count;
    data_mask = 8'((9'd1 << n_sat) - 9'd1);
    acc       = (13'(leftover_bits_r) << n_sat) | 13'(in_data.data_bits & data_mask);
    cnt       = 4'(leftover_count_r) + n_sat;
    if (cnt >= 4'd12) begin
      full_groups = 2'd2;
      rem         = 3'(cnt - 4'd12);
    end else if (cnt >= 4'd6) begin
      full_groups = 2'd1;
      rem         = 3'(cnt - 4'd6);
    end else begin
      full_groups = 2'd0;
      rem         = 3'(cnt);
    end
    g_first  = 6'(acc >> (cnt - 4'd6));
    g_second = 6'(acc >> (cnt - 4'd12));
    rem_bits = 5'(acc & ((13'd1 << rem) - 13'd1));
    part     = 6'(11'(rem_bits) << (3'd6 - rem));
    has_part = in_data.message_last && (rem != 3'd0);

    job      = '0;
    job.grp[0] = (full_groups != 2'd0) ? g_first : part;
    job.grp[1] = (full_groups == 2'd2) ? g_second : part;
    job.grp[2] = part;
    job.num    = full_groups + 2'(has_part);
    job.fill   = has_part ? (3'd6 - rem) : 3'd0;
    job.last   = in_data.message_last;
  end

  // Queue work only when it produces a character or closes a message
  assign job_push  = accept && ((job.num != 2'd0) || job.last);
  assign job_wdata = job;

  // Hold the bits that do not yet make a group; drop them at message end
  always_comb begin
    leftover_bits_nxt  = leftover_bits_r;
    leftover_count_nxt = leftover_count_r;
    if (accept) begin
      leftover_bits_nxt  = in_data.message_last ? 5'd0 : rem_bits;
      leftover_count_nxt = in_data.message_last ? 3'd0 : rem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leftover_bits_r  <= '0;
      leftover_count_r <= '0;
    end else begin
      leftover_bits_r  <= leftover_bits_nxt;
      leftover_count_r <= leftover_count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_leftover_bound: assert property (@(posedge clk) disable iff (!rst_n)
    leftover_count_r <= 3'd5)
    else $error("more than five waiting bits");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.message_last) |=> (leftover_count_r == 3'd0))
    else $error("waiting bits kept past message end");
`endif

endmodule

FILE: sv/apaf_back.sv
// ----------------------------------------------------------------------------
// apaf_back
// Emit one armored character per cycle from the queued groups while the result
// queue has room; count fragment characters; hold the fragment length register.
// ----------------------------------------------------------------------------
module apaf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic [6:0]         cfg_data,
  input  logic               job_empty,
  input  apaf_pkg::job_t     job_rdata,
  output logic               job_pop,
  input  logic               out_full,
  output logic               out_push,
  output apaf_pkg::out_item_t out_wdata
);
  import apaf_pkg::*;

  logic [FRAG_LEN_W-1:0] frag_len_r;
  logic [FRAG_LEN_W-1:0] frag_cnt_r, frag_cnt_nxt;
  logic [1:0]            idx_r, idx_nxt;
  logic [FRAG_LEN_W-1:0] limit;
  logic [FRAG_LEN_W-1:0] cnt_inc;
  logic                  go;
  logic                  no_chars;
  logic                  is_final;
  logic                  end_flag;
  out_item_t             item;

  assign limit    = (frag_len_r == '0) ? FRAG_LEN_W'(1) : frag_len_r;
  assign go       = !job_empty && !out_full;
  assign no_chars = (job_rdata.num == 2'd0);
  assign is_final = no_chars || (idx_r == (job_rdata.num - 2'd1));
  assign cnt_inc  = frag_cnt_r + 1'b1;
  assign end_flag = (cnt_inc >= limit) || (job_rdata.last && is_final);

  // Build the character beat
  always_comb begin
    item.armored_char = armor_char(job_rdata.grp[idx_r]);
    item.fragment_end = end_flag;
    item.fill_bits    = is_final ? job_rdata.fill : 3'd0;
    item.run_last     = is_final;
  end

  assign out_push  = go && !no_chars;
  assign out_wdata = item;
  assign job_pop   = go && is_final;

  // Advance group index and fragment count
  always_comb begin
    idx_nxt      = idx_r;
    frag_cnt_nxt = frag_cnt_r;
    if (go) begin
      idx_nxt = is_final ? 2'd0 : idx_r + 2'd1;
      if (no_chars || end_flag) begin
        frag_cnt_nxt = '0;
      end else begin
        frag_cnt_nxt = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r      <= '0;
      frag_cnt_r <= '0;
      frag_len_r <= FRAG_LEN_RESET;
    end else begin
      idx_r      <= idx_nxt;
      frag_cnt_r <= frag_cnt_nxt;
      if (cfg_valid) begin
        frag_len_r <= cfg_data;
      end
    end
  end

`ifndef SYNTHESIS
  a_msg_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (job_pop && job_rdata.last) |=> (frag_cnt_r == '0))
    else $error("fragment count kept past message end");

  a_run_last_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_push |-> (out_wdata.run_last == job_pop))
    else $error("run_last out of step with job retire");

  a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
    (!job_empty && !no_chars) |-> (idx_r < job_rdata.num))
    else $error("group index beyond job");
`endif

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the six-bit payload armor fragmenter. Chunks of
// message bits go in through the input queue and a scoreboard works out the
// armored characters, fragment closes and fill-bit counts each one should
// cause. Every character taken from the result queue is checked in order.
// Directed corner chunks run first, then random messages over a range of
// fragment lengths, with random bursts on the input side and stalls on the
// result side.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import apaf_pkg::*;

  // Receiver stall patterns
  localparam int RX_FREE    = 0;
  localparam int RX_COIN    = 1;
  localparam int RX_CADENCE = 2;
  localparam int RX_STALLS  = 3;

  localparam int SETTLE_CYCLES = 10;
  localparam int NUM_PHASES    = 8;

  // --------------------------------------------------------------------------
  // Scoreboard: bit packer, armoring and fragment counting
  // --------------------------------------------------------------------------
  class armor_scoreboard;
    out_item_t            expected_chars[$];
    logic [4:0]           wait_bits;
    logic [2:0]           wait_cnt;
    logic [FRAG_LEN_W-1:0] frag_cnt;
    logic [FRAG_LEN_W-1:0] frag_len;
    int errors;
    int chunks;
    int chars;
    int closes;
    int padded;

    function new();
      wait_bits = '0;
      wait_cnt  = '0;
      frag_cnt  = '0;
      frag_len  = FRAG_LEN_RESET;
      errors    = 0;
      chunks    = 0;
      chars     = 0;
      closes    = 0;
      padded    = 0;
    endfunction

    function void set_length(logic [FRAG_LEN_W-1:0] len);
      frag_len = len;
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction

    // Armor one group and advance the fragment count
    function out_item_t next_char(int grp);
      out_item_t c;
      logic [FRAG_LEN_W-1:0] limit;
      limit          = (frag_len == '0) ? 7'd1 : frag_len;
      frag_cnt       = frag_cnt + 7'd1;
      c.armored_char = (grp < 40) ? 7'(grp + 48) : 7'(grp + 56);
      c.fragment_end = (frag_cnt >= limit);
      c.fill_bits    = '0;
      c.run_last     = 1'b0;
      if (c.fragment_end) begin
        frag_cnt = '0;
      end
      return c;
    endfunction

    // Pack an accepted chunk and queue the characters it completes
    function void note_chunk(in_item_t it);
      out_item_t run[MAX_GROUPS];
      int n;
      int cnt;
      int acc;
      int k;
      int fill;
      chunks++;
      n   = (it.bit_count > 4'd8) ? 8 : int'(it.bit_count);
      cnt = (wait_cnt > 3'd5) ? 5 : int'(wait_cnt);
      acc = ((int'(wait_bits) & ((1 << cnt) - 1)) << n) |
            (int'(it.data_bits) & ((1 << n) - 1));
      cnt += n;
      k = 0;
      while (cnt >= GROUP_W && k < MAX_GROUPS) begin
        cnt -= GROUP_W;
        run[k] = next_char((acc >> cnt) & 'h3f);
        acc &= (1 << cnt) - 1;
        k++;
      end
      // Flush left-aligned leftovers and close the fragment at message end
      if (it.message_last) begin
        if (cnt > 0) begin
          fill = GROUP_W - cnt;
          run[k] = next_char((acc << fill) & 'h3f);
          run[k].fragment_end = 1'b1;
          run[k].fill_bits    = 3'(fill);
          k++;
        end else if (k > 0) begin
          run[k-1].fragment_end = 1'b1;
        end
        acc      = 0;
        cnt      = 0;
        frag_cnt = '0;
      end
      wait_bits = 5'(acc);
      wait_cnt  = 3'(cnt);
      if (k > 0) begin
        run[k-1].run_last = 1'b1;
      end
      for (int i = 0; i < k; i++) begin
        expected_chars.insert(expected_chars.size(), run[i]);
      end
    endfunction

    task log_error(string msg);
      errors++;
      $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    // Compare one popped character with the oldest expectation
    task check_char(out_item_t got);
      out_item_t want;
      chars++;
      if (got.fragment_end === 1'b1) closes++;
      if (got.fill_bits !== 3'd0) padded++;
      if (expected_chars.size() == 0) begin
        log_error($sformatf("unexpected character 0x%02h", got.armored_char));
        return;
      end
      want = expected_chars.pop_front();
      if (got.armored_char !== want.armored_char)
        log_error($sformatf("char %0d: armored_char 0x%02h, want 0x%02h",
                            chars, got.armored_char, want.armored_char));
      if (got.fragment_end !== want.fragment_end)
        log_error($sformatf("char %0d: fragment_end %b, want %b",
                            chars, got.fragment_end, want.fragment_end));
      if (got.fill_bits !== want.fill_bits)
        log_error($sformatf("char %0d: fill_bits %0d, want %0d",
                            chars, got.fill_bits, want.fill_bits));
      if (got.run_last !== want.run_last)
        log_error($sformatf("char %0d: run_last %b, want %b",
                            chars, got.run_last, want.run_last));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block
  // --------------------------------------------------------------------------
  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_push   = 1'b0;
  in_item_t  in_data   = '0;
  logic      in_full;
  logic      out_empty;
  logic      out_pop   = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [6:0] cfg_data = '0;

  armor_scoreboard sb = new();

  int rx_mode   = RX_FREE;
  int rx_tick   = 0;
  int rx_hold   = 0;
  bit gap_on    = 1'b1;
  int burst_left = 0;

  always #5 clk = ~clk;

  ais_payload_armor_fragmenter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Watch both queues: note accepted chunks, check popped characters
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full) sb.note_chunk(in_data);
      if (out_pop && !out_empty) sb.check_char(out_data);
    end
  end

  // Drive the receiver side on the current stall pattern
  always @(posedge clk) begin
    rx_tick++;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      case (rx_mode)
        RX_FREE: begin
          out_pop <= 1'b1;
        end
        RX_COIN: begin
          out_pop <= ($urandom_range(0, 1) == 1);
        end
        RX_CADENCE: begin
          out_pop <= (rx_tick % 3) != 0;
        end
        RX_STALLS: begin
          if (rx_hold > 0) begin
            rx_hold--;
            out_pop <= 1'b0;
          end else begin
            out_pop <= 1'b1;
            if ($urandom_range(0, 2) == 0) rx_hold = $urandom_range(1, 12);
          end
        end
        default: begin
          out_pop <= 1'b1;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------
  function automatic in_item_t mk(logic [7:0] d, logic [3:0] n, logic l);
    in_item_t it;
    it.data_bits    = d;
    it.bit_count    = n;
    it.message_last = l;
    return it;
  endfunction

  // Push one beat; open a gap between bursts when gaps are on
  task automatic push_chunk(in_item_t it);
    if (burst_left == 0) begin
      if (gap_on) begin
        in_push <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_push <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_full) @(posedge clk);
    burst_left--;
  endtask

  // Drop push, drain every expected character, then let the pipe settle
  task automatic wait_idle();
    in_push <= 1'b0;
    burst_left = 0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(logic [6:0] len);
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_length(len);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int len_tab[NUM_PHASES];
    int cnt_tab[NUM_PHASES];
    in_item_t it;
    int msg_left;
    bit long_msg;

    len_tab = '{1, 80, 0, 127, 3, 56, 21, 0};
    cnt_tab = '{40, 64, 30, 120, 40, 80, 30, 30};
    len_tab[NUM_PHASES-1] = $urandom_range(1, 80);
    msg_left = 0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed corners at the reset fragment length
    push_chunk(mk(8'd39, 4'd6, 1'b0));   // top of the low character range
    push_chunk(mk(8'd40, 4'd6, 1'b0));   // bottom of the high range
    push_chunk(mk(8'hC0, 4'd6, 1'b0));   // bits above the count are ignored
    push_chunk(mk(8'hFF, 4'd6, 1'b1));   // message ends on a full group
    push_chunk(mk(8'h00, 4'd0, 1'b1));   // end with nothing to emit
    push_chunk(mk(8'h01, 4'd1, 1'b1));   // one bit, five fill bits
    push_chunk(mk(8'hFF, 4'd0, 1'b0));   // zero bit count adds nothing
    push_chunk(mk(8'h1F, 4'd5, 1'b0));   // five bits left waiting
    push_chunk(mk(8'hFF, 4'd8, 1'b1));   // three characters from one chunk
    push_chunk(mk(8'hAB, 4'd15, 1'b0));  // oversize counts saturate
    push_chunk(mk(8'h5A, 4'd9, 1'b0));
    push_chunk(mk(8'h00, 4'd2, 1'b1));
    push_chunk(mk(8'h55, 4'd7, 1'b0));
    push_chunk(mk(8'hAA, 4'd3, 1'b0));
    push_chunk(mk(8'h3C, 4'd2, 1'b0));
    push_chunk(mk(8'h0F, 4'd4, 1'b1));
    push_chunk(mk(8'h80, 4'd8, 1'b0));
    push_chunk(mk(8'h00, 4'd8, 1'b0));
    push_chunk(mk(8'hFF, 4'd8, 1'b1));
    wait_idle();

    // Random messages over a sweep of fragment lengths
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_length(7'(len_tab[ph]));
      rx_mode  = (ph == 6) ? RX_FREE : ph % 4;
      gap_on   = !(ph == 2 || ph == 6);
      long_msg = len_tab[ph] >= 56;
      // Long phases keep their byte message open past the phase end, so the next
      // length takes effect in the middle of a fragment
      if (long_msg) msg_left = cnt_tab[ph] + 1;
      for (int i = 0; i < cnt_tab[ph]; i++) begin
        if (long_msg) begin
          it = mk(8'($urandom_range(0, 255)), 4'd8, 1'b0);
          msg_left--;
        end else if ($urandom_range(0, 99) < 15) begin
          it = mk(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                  $urandom_range(0, 3) == 0);
          if (it.message_last) msg_left = 0;
        end else begin
          if (msg_left == 0) begin
            msg_left = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8)
                                                  : $urandom_range(9, 40);
          end
          it = mk(8'($urandom_range(0, 255)),
                  ($urandom_range(0, 1) == 1) ? 4'd8 : 4'($urandom_range(1, 8)),
                  msg_left == 1);
          msg_left--;
        end
        push_chunk(it);
      end
      wait_idle();
    end

    $display("Run covered %0d chunks and %0d characters: %0d fragment closes,",
             sb.chunks, sb.chars, sb.closes);
    $display("%0d padded message ends, fragment lengths 56 1 80 0 127 3 56 21 %0d.",
             sb.padded, len_tab[NUM_PHASES-1]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // Hard stop if the block hangs
  initial begin : watchdog
    #(2_000_000);
    $display("tb failed");
    $finish;
  end

endmodule

FILE: sim.f
sv/apaf_pkg.sv
sv/apaf_fifo.sv
sv/apaf_front.sv
sv/apaf_back.sv
sv/ais_payload_armor_fragmenter.sv
tb/sv/tb.sv
